/* hdl/bmlr_pkg.sv */
// Shared types and constants for the bank mapper with latched RTC.
// Used by the controller, the datapath, the top level and the checker.
package bmlr_pkg;

  // Item kinds on the input tuser
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // Result kinds on the output tuser
  localparam logic [2:0] TGT_NONE      = 3'd0;
  localparam logic [2:0] TGT_ROM_READ  = 3'd1;
  localparam logic [2:0] TGT_RAM_READ  = 3'd2;
  localparam logic [2:0] TGT_RAM_WRITE = 3'd3;
  localparam logic [2:0] TGT_RTC       = 3'd4;

  // Configuration register indexes
  localparam logic CFG_ROM_BANK_COUNT = 1'b0;
  localparam logic CFG_RAM_BYTES      = 1'b1;

  // Largest ROM bank count honoured
  localparam logic [7:0] MAX_ROM_BANKS = 8'd128;

  // Payload widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // capture the accepted transaction
    logic div_hi;  // remainder steps for bank bits 6..3
    logic div_lo;  // remainder steps for bank bits 2..0
    logic commit;  // update state and load the output register
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } dp_stat_t;

endpackage

/* hdl/bmlr_ctrl.sv */
// Sequencer for the bank mapper: accept, two remainder steps, commit.
// Depends on bmlr_pkg for the command and status structs.
module bmlr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bmlr_pkg::dp_stat_t stat,
  output bmlr_pkg::dp_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV_HI = 2'd1;
  localparam logic [1:0] ST_DIV_LO = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Take a transaction only when idle and out of reset
  assign in_ready = (state == ST_IDLE) && !rst;

  // Decode commands and the next state
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV_HI;
        end
      end
      ST_DIV_HI: begin
        cmd.div_hi = 1'b1;
        state_next = ST_DIV_LO;
      end
      ST_DIV_LO: begin
        cmd.div_lo = 1'b1;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        // Hold until the output register is free
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hdl/bmlr_dp.sv */
// Datapath of the bank mapper: mapper registers, RTC counters, latch,
// ROM bank remainder unit and the output register. Depends on bmlr_pkg.
module bmlr_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [15:0]                          cfg_data,
  input  logic [1:0]                           in_tuser,
  input  logic [bmlr_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  bmlr_pkg::dp_cmd_t                    cmd,
  output bmlr_pkg::dp_stat_t                   stat,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [2:0]                           out_tuser,
  output logic [bmlr_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  // Address regions by bits 15..13
  localparam logic [2:0] REG_RAM_EN   = 3'd0;
  localparam logic [2:0] REG_ROM_BANK = 3'd1;
  localparam logic [2:0] REG_SEL      = 3'd2;
  localparam logic [2:0] REG_LATCH    = 3'd3;
  localparam logic [2:0] REG_RAM_WIN  = 3'd5;

  // RTC register indexes
  localparam logic [2:0] RTC_SEC   = 3'd0;
  localparam logic [2:0] RTC_MIN   = 3'd1;
  localparam logic [2:0] RTC_HOUR  = 3'd2;
  localparam logic [2:0] RTC_DAY_L = 3'd3;
  localparam logic [2:0] RTC_DAY_H = 3'd4;

  // One restoring remainder step
  function automatic logic [7:0] mod_step(input logic [7:0] r, input logic b,
                                          input logic [7:0] d);
    logic [7:0] t;
    t = {r[6:0], b};
    mod_step = (t >= d) ? (t - d) : t;
  endfunction

  function automatic logic [5:0] mod60(input logic [7:0] v);
    logic [7:0] t;
    t = v;
    if (t >= 8'd240) t = t - 8'd240;
    if (t >= 8'd120) t = t - 8'd120;
    if (t >= 8'd60)  t = t - 8'd60;
    mod60 = t[5:0];
  endfunction

  function automatic logic [4:0] mod24(input logic [7:0] v);
    logic [7:0] t;
    t = v;
    if (t >= 8'd192) t = t - 8'd192;
    if (t >= 8'd96)  t = t - 8'd96;
    if (t >= 8'd48)  t = t - 8'd48;
    if (t >= 8'd24)  t = t - 8'd24;
    mod24 = t[4:0];
  endfunction

  // Configuration
  logic [7:0]  rom_bank_count;
  logic [15:0] ram_bytes;

  // Mapper state
  logic       ram_enabled;
  logic [6:0] rom_bank_sel;
  logic [7:0] bank_or_rtc_sel;
  logic       latch_prev_bit;
  logic       latched_flag;

  // RTC
  logic       halt_flag;
  logic       day_carry_flag;
  logic [5:0] sec_count;
  logic [5:0] min_count;
  logic [4:0] hour_count;
  logic [8:0] day_counter;
  logic [7:0] latched_rtc [5];

  // Captured transaction and remainder unit
  logic [1:0]  item_mode;
  logic [15:0] item_addr;
  logic [7:0]  item_wd;
  logic [6:0]  num;
  logic [7:0]  rem_r;

  logic [7:0]  eff_n;
  logic [6:0]  bank_fix;
  logic [2:0]  ram_nbanks;
  logic [1:0]  ram_bsel;
  logic [14:0] ram_off;
  logic        ram_ok;
  logic        in_ram_win;
  logic        sel_ram;
  logic        sel_rtc;
  logic [2:0]  rtc_idx;
  logic [7:0]  live_rtc [5];
  logic [7:0]  rtc_read;
  logic [2:0]  res_target;
  logic [20:0] res_rom;
  logic [14:0] res_ram;
  logic [7:0]  res_data;
  logic [5:0]  t_sec;
  logic [5:0]  t_min;
  logic [4:0]  t_hour;
  logic [8:0]  t_day;
  logic        t_carry;
  logic [6:0]  in_wbank;

  // Clamp the ROM bank count
  always_comb begin
    if (rom_bank_count == 8'd0) begin
      eff_n = 8'd1;
    end else if (rom_bank_count > bmlr_pkg::MAX_ROM_BANKS) begin
      eff_n = bmlr_pkg::MAX_ROM_BANKS;
    end else begin
      eff_n = rom_bank_count;
    end
  end

  // Bank zero maps to one when more than one bank exists
  assign bank_fix = ((rem_r[6:0] == 7'd0) && (eff_n > 8'd1)) ? 7'd1 : rem_r[6:0];

  // RAM bank mapping; the select is at most three here
  assign ram_nbanks = (ram_bytes[15:13] == 3'd0) ? 3'd1 : ram_bytes[15:13];
  always_comb begin
    case (ram_nbanks)
      3'd1:    ram_bsel = 2'd0;
      3'd2:    ram_bsel = {1'b0, bank_or_rtc_sel[0]};
      3'd3:    ram_bsel = (bank_or_rtc_sel[1:0] == 2'd3) ? 2'd0 : bank_or_rtc_sel[1:0];
      default: ram_bsel = bank_or_rtc_sel[1:0];
    endcase
  end
  assign ram_off    = {ram_bsel, item_addr[12:0]};
  assign ram_ok     = (ram_bytes != 16'd0) && ({1'b0, ram_off} < ram_bytes);
  assign in_ram_win = (item_addr[15:13] == REG_RAM_WIN) && ram_enabled;
  assign sel_ram    = bank_or_rtc_sel <= 8'd3;
  assign sel_rtc    = (bank_or_rtc_sel >= 8'h08) && (bank_or_rtc_sel <= 8'h0C);
  assign rtc_idx    = bank_or_rtc_sel[2:0];

  // Live RTC register view
  assign live_rtc[0] = {2'b00, sec_count};
  assign live_rtc[1] = {2'b00, min_count};
  assign live_rtc[2] = {3'b000, hour_count};
  assign live_rtc[3] = day_counter[7:0];
  assign live_rtc[4] = {day_carry_flag, halt_flag, 5'b00000, day_counter[8]};

  always_comb begin
    case (rtc_idx)
      RTC_SEC:   rtc_read = latched_flag ? latched_rtc[0] : live_rtc[0];
      RTC_MIN:   rtc_read = latched_flag ? latched_rtc[1] : live_rtc[1];
      RTC_HOUR:  rtc_read = latched_flag ? latched_rtc[2] : live_rtc[2];
      RTC_DAY_L: rtc_read = latched_flag ? latched_rtc[3] : live_rtc[3];
      default:   rtc_read = latched_flag ? latched_rtc[4] : live_rtc[4];
    endcase
  end

  // Form the result of the held transaction
  always_comb begin
    res_target = bmlr_pkg::TGT_NONE;
    res_rom    = '0;
    res_ram    = '0;
    res_data   = 8'hFF;
    if (item_mode == bmlr_pkg::MODE_READ) begin
      if (item_addr[15:14] == 2'd0) begin
        res_target = bmlr_pkg::TGT_ROM_READ;
        res_rom    = {7'd0, item_addr[13:0]};
      end else if (item_addr[15:14] == 2'd1) begin
        res_target = bmlr_pkg::TGT_ROM_READ;
        res_rom    = {bank_fix, item_addr[13:0]};
      end else if (in_ram_win) begin
        if (sel_ram) begin
          if (ram_ok) begin
            res_target = bmlr_pkg::TGT_RAM_READ;
            res_ram    = ram_off;
          end
        end else if (sel_rtc) begin
          res_target = bmlr_pkg::TGT_RTC;
          res_data   = rtc_read;
        end
      end
    end else if (item_mode == bmlr_pkg::MODE_WRITE) begin
      if (in_ram_win && sel_ram && ram_ok) begin
        res_target = bmlr_pkg::TGT_RAM_WRITE;
        res_ram    = ram_off;
        res_data   = item_wd;
      end
    end
  end

  // Next RTC value on a one-second tick
  always_comb begin
    t_sec   = sec_count;
    t_min   = min_count;
    t_hour  = hour_count;
    t_day   = day_counter;
    t_carry = day_carry_flag;
    if (!halt_flag) begin
      if (({1'b0, sec_count} + 7'd1) < 7'd60) begin
        t_sec = sec_count + 6'd1;
      end else begin
        t_sec = 6'd0;
        if (({1'b0, min_count} + 7'd1) < 7'd60) begin
          t_min = min_count + 6'd1;
        end else begin
          t_min = 6'd0;
          if (({1'b0, hour_count} + 6'd1) < 6'd24) begin
            t_hour = hour_count + 5'd1;
          end else begin
            t_hour = 5'd0;
            if (day_counter == 9'd511) begin
              t_day   = 9'd0;
              t_carry = 1'b1;
            end else begin
              t_day = day_counter + 9'd1;
            end
          end
        end
      end
    end
  end

  // Numerator for a bank write: zero becomes one
  assign in_wbank = (in_tdata[22:16] == 7'd0) ? 7'd1 : in_tdata[22:16];

  // Capture the transaction and run the remainder unit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_mode <= in_tuser;
      item_addr <= in_tdata[15:0];
      item_wd   <= in_tdata[23:16];
      num       <= (in_tuser == bmlr_pkg::MODE_WRITE) ? in_wbank : rom_bank_sel;
      rem_r     <= 8'd0;
    end else if (cmd.div_hi) begin
      rem_r <= mod_step(mod_step(mod_step(mod_step(rem_r, num[6], eff_n),
                                          num[5], eff_n), num[4], eff_n), num[3], eff_n);
    end else if (cmd.div_lo) begin
      rem_r <= mod_step(mod_step(mod_step(rem_r, num[2], eff_n), num[1], eff_n),
                        num[0], eff_n);
    end
  end

  // Configuration and state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank_count  <= 8'd2;
      ram_bytes       <= 16'd0;
      ram_enabled     <= 1'b0;
      rom_bank_sel    <= 7'd1;
      bank_or_rtc_sel <= 8'd0;
      latch_prev_bit  <= 1'b0;
      latched_flag    <= 1'b0;
      halt_flag       <= 1'b0;
      day_carry_flag  <= 1'b0;
      sec_count       <= 6'd0;
      min_count       <= 6'd0;
      hour_count      <= 5'd0;
      day_counter     <= 9'd0;
      for (int i = 0; i < 5; i++) begin
        latched_rtc[i] <= 8'd0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bmlr_pkg::CFG_ROM_BANK_COUNT: rom_bank_count <= cfg_data[7:0];
          default:                      ram_bytes      <= cfg_data;
        endcase
      end
      if (cmd.commit) begin
        if (item_mode == bmlr_pkg::MODE_TICK) begin
          sec_count      <= t_sec;
          min_count      <= t_min;
          hour_count     <= t_hour;
          day_counter    <= t_day;
          day_carry_flag <= t_carry;
        end else if (item_mode == bmlr_pkg::MODE_WRITE) begin
          case (item_addr[15:13])
            REG_RAM_EN: begin
              ram_enabled <= (item_wd[3:0] == 4'hA);
            end
            REG_ROM_BANK: begin
              rom_bank_sel <= bank_fix;
            end
            REG_SEL: begin
              bank_or_rtc_sel <= item_wd;
            end
            REG_LATCH: begin
              // Snapshot on a rising latch bit, drop the snapshot on zero
              if (!latch_prev_bit && item_wd[0]) begin
                for (int i = 0; i < 5; i++) begin
                  latched_rtc[i] <= live_rtc[i];
                end
                latched_flag <= 1'b1;
              end
              if (!item_wd[0]) begin
                latched_flag <= 1'b0;
              end
              latch_prev_bit <= item_wd[0];
            end
            REG_RAM_WIN: begin
              if (ram_enabled && !sel_ram && sel_rtc) begin
                case (rtc_idx)
                  RTC_SEC:   sec_count   <= mod60(item_wd);
                  RTC_MIN:   min_count   <= mod60(item_wd);
                  RTC_HOUR:  hour_count  <= mod24(item_wd);
                  RTC_DAY_L: day_counter <= {day_counter[8], item_wd};
                  RTC_DAY_H: begin
                    day_counter    <= {item_wd[0], day_counter[7:0]};
                    halt_flag      <= item_wd[6];
                    day_carry_flag <= item_wd[7];
                  end
                  default: begin
                    day_counter <= day_counter;
                  end
                endcase
              end
            end
            default: begin
              ram_enabled <= ram_enabled;
            end
          endcase
        end
      end
    end
  end

  // Output register parts the two sides
  assign stat.out_free = !out_tvalid || out_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_tuser <= res_target;
      out_tdata <= {4'b0000, res_data, res_ram, res_rom};
    end
  end

endmodule

/* hdl/bank_mapper_with_latched_rtc.sv */
// Cartridge bank mapper with a latched real-time clock.
// Order: the accepted transaction is captured, the ROM bank remainder unit runs its
// high and low steps, and the commit step loads the output register, waiting while the
// output is full. A new transaction is taken only after the last one has committed.
// Reset: synchronous, active high; clears all mapper, RTC and control state
// at once and restores rom_bank_count 2 and ram_bytes 0. No clearing pass.
module bank_mapper_with_latched_rtc (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [15:0]                      cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [bmlr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // address[15:0], write_data[23:16]
  input  logic [1:0]                       s_axis_tuser,   // mode[1:0]
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [bmlr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // rom_address[20:0],
                                                           // ram_address[35:21], data[43:36]
  output logic [2:0]                       m_axis_tuser    // target[2:0]
);

  bmlr_pkg::dp_cmd_t  cmd;
  bmlr_pkg::dp_stat_t stat;

  bmlr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bmlr_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tuser   (s_axis_tuser),
    .in_tdata   (s_axis_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (m_axis_tvalid),
    .out_tready (m_axis_tready),
    .out_tuser  (m_axis_tuser),
    .out_tdata  (m_axis_tdata)
  );

endmodule

/* hdl/bmlr_checker.sv */
// Port-level checks for the bank mapper, bound to the top level.
// Depends on bmlr_pkg for the result kind codes.
module bmlr_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [bmlr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [2:0]                       m_axis_tuser
);

  // No result straight after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // One transaction at a time: not ready right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready straight after accept");

  // The RAM address field reads as zero and data as all ones for empty and ROM results
  a_fill: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == bmlr_pkg::TGT_NONE
      || m_axis_tuser == bmlr_pkg::TGT_ROM_READ)
    |-> m_axis_tdata[35:21] == 15'd0 && m_axis_tdata[43:36] == 8'hFF)
    else $error("bad fill for empty or ROM result");

  // Result kind within range
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser <= bmlr_pkg::TGT_RTC)
    else $error("result kind out of range");

endmodule

bind bank_mapper_with_latched_rtc bmlr_checker u_bmlr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* tb/sv/mapper_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the bank mapper with latched RTC: predicts each result from
// the accepted input transactions and compares it with the output stream.
// Depends on bmlr_pkg for item kinds, result kinds and register indexes.
module mapper_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [15:0]                       cfg_data,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [bmlr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // address[15:0], write_data[23:16]
  input  logic [1:0]                        s_axis_tuser,   // mode[1:0]
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [bmlr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // rom_address[20:0],
                                                            // ram_address[35:21],
                                                            // data[43:36]
  input  logic [2:0]                        m_axis_tuser,   // target[2:0]
  output int                                err_count,
  output int                                pending,
  output int                                checked
);

  // Bus windows
  localparam logic [15:0] WIN_ROM_BANK = 16'h2000;
  localparam logic [15:0] WIN_SELECT   = 16'h4000;
  localparam logic [15:0] WIN_LATCH    = 16'h6000;
  localparam logic [15:0] WIN_END      = 16'h8000;
  localparam logic [15:0] EXT_RAM_LO   = 16'hA000;
  localparam logic [15:0] EXT_RAM_HI   = 16'hBFFF;

  // Bank/RTC select codes and RTC register indexes
  localparam logic [7:0] RAM_SEL_LAST  = 8'h03;
  localparam logic [7:0] SEL_RTC_FIRST = 8'h08;
  localparam logic [7:0] SEL_RTC_LAST  = 8'h0C;
  localparam int RTC_SEC    = 0;
  localparam int RTC_MIN    = 1;
  localparam int RTC_HOUR   = 2;
  localparam int RTC_DAY_LO = 3;
  localparam int RTC_DAY_HI = 4;

  localparam int unsigned RAM_BANK_BYTES = 8192;
  localparam int unsigned DAY_WRAP       = 512;

  typedef struct packed {
    logic [2:0]  target;
    logic [20:0] rom_addr;
    logic [14:0] ram_addr;
    logic [7:0]  data;
  } map_result_t;

  // Geometry as written over the configuration port
  logic [7:0]  rom_count;
  logic [15:0] ram_len;

  // Mapper and clock state
  logic        ram_on;
  logic [6:0]  rom_sel;
  logic [7:0]  sel_reg;
  logic        latch_last;
  logic        latch_on;
  logic        halted;
  logic        carry;
  int unsigned secs, mins, hours, days;
  logic [7:0]  snapshot [5];

  map_result_t expected_q [$];
  map_result_t want, got;
  int          fails = 0;
  int          n_checked = 0;

  task automatic reset_model();
    rom_count  = 8'd2;
    ram_len    = 16'd0;
    ram_on     = 1'b0;
    rom_sel    = 7'd1;
    sel_reg    = 8'd0;
    latch_last = 1'b0;
    latch_on   = 1'b0;
    halted     = 1'b0;
    carry      = 1'b0;
    secs       = 0;
    mins       = 0;
    hours      = 0;
    days       = 0;
    for (int i = 0; i < 5; i++) snapshot[i] = 8'd0;
  endtask

  function automatic logic [7:0] rtc_reg(input int idx);
    case (idx)
      RTC_SEC:    return secs[7:0];
      RTC_MIN:    return mins[7:0];
      RTC_HOUR:   return hours[7:0];
      RTC_DAY_LO: return days[7:0];
      default:    return {carry, halted, 5'd0, days[8]};
    endcase
  endfunction

  // Writes wrap into range by modulo; the day high register also carries halt and carry
  function automatic void set_rtc_reg(input int idx, input logic [7:0] wd);
    case (idx)
      RTC_SEC:    secs = wd % 60;
      RTC_MIN:    mins = wd % 60;
      RTC_HOUR:   hours = wd % 24;
      RTC_DAY_LO: days = ((days & 32'h100) | wd) % DAY_WRAP;
      default: begin
        days   = ({wd[0], 8'd0} | (days & 32'hFF)) % DAY_WRAP;
        halted = wd[6];
        carry  = wd[7];
      end
    endcase
  endfunction

  // One second: ripple through the counters, wrap the day count into carry
  function automatic void advance_clock();
    if (halted) return;
    secs++;
    if (secs < 60) return;
    secs = 0;
    mins++;
    if (mins < 60) return;
    mins = 0;
    hours++;
    if (hours < 24) return;
    hours = 0;
    days++;
    if (days >= DAY_WRAP) begin
      days  = 0;
      carry = 1'b1;
    end
  endfunction

  // External RAM offset for the selected bank; false when beyond the RAM
  function automatic logic map_ram(input logic [15:0] addr, output logic [14:0] off);
    int unsigned banks, o;
    off = '0;
    if (ram_len == 16'd0) return 1'b0;
    banks = ram_len / RAM_BANK_BYTES;
    if (banks == 0) banks = 1;
    o = (sel_reg % banks) * RAM_BANK_BYTES + (addr - EXT_RAM_LO);
    off = o[14:0];
    return o < ram_len;
  endfunction

  function automatic map_result_t predict_access(input logic [1:0] mode,
                                                 input logic [15:0] addr,
                                                 input logic [7:0] wd);
    map_result_t r;
    int unsigned n, bank, acc;
    logic [14:0] off;
    logic        ext;
    r.target   = bmlr_pkg::TGT_NONE;
    r.rom_addr = '0;
    r.ram_addr = '0;
    r.data     = 8'hFF;
    n = (rom_count == 8'd0) ? 1 :
        (rom_count > bmlr_pkg::MAX_ROM_BANKS) ? bmlr_pkg::MAX_ROM_BANKS : rom_count;
    ext = (addr >= EXT_RAM_LO) && (addr <= EXT_RAM_HI) && ram_on;
    case (mode)
      bmlr_pkg::MODE_TICK: advance_clock();
      bmlr_pkg::MODE_READ: begin
        if (addr < WIN_SELECT) begin
          r.target   = bmlr_pkg::TGT_ROM_READ;
          r.rom_addr = {5'd0, addr};
        end else if (addr < WIN_END) begin
          bank = rom_sel % n;
          if (bank == 0 && n > 1) bank = 1;
          acc        = bank * 32'h4000 + addr[13:0];
          r.target   = bmlr_pkg::TGT_ROM_READ;
          r.rom_addr = acc[20:0];
        end else if (ext) begin
          if (sel_reg <= RAM_SEL_LAST) begin
            if (map_ram(addr, off)) begin
              r.target   = bmlr_pkg::TGT_RAM_READ;
              r.ram_addr = off;
            end
          end else if (sel_reg >= SEL_RTC_FIRST && sel_reg <= SEL_RTC_LAST) begin
            r.target = bmlr_pkg::TGT_RTC;
            r.data   = latch_on ? snapshot[sel_reg - SEL_RTC_FIRST]
                                : rtc_reg(sel_reg - SEL_RTC_FIRST);
          end
        end
      end
      bmlr_pkg::MODE_WRITE: begin
        if (addr < WIN_ROM_BANK) begin
          ram_on = (wd[3:0] == 4'hA);
        end else if (addr < WIN_SELECT) begin
          bank = wd[6:0];
          if (bank == 0) bank = 1;
          bank = bank % n;
          if (bank == 0 && n > 1) bank = 1;
          if (n == 1) bank = 0;
          rom_sel = bank[6:0];
        end else if (addr < WIN_LATCH) begin
          sel_reg = wd;
        end else if (addr < WIN_END) begin
          // Snapshot on a rising latch bit; a low bit drops the snapshot
          if (!latch_last && wd[0]) begin
            for (int i = 0; i < 5; i++) snapshot[i] = rtc_reg(i);
            latch_on = 1'b1;
          end
          if (!wd[0]) latch_on = 1'b0;
          latch_last = wd[0];
        end else if (ext) begin
          if (sel_reg <= RAM_SEL_LAST) begin
            if (map_ram(addr, off)) begin
              r.target   = bmlr_pkg::TGT_RAM_WRITE;
              r.ram_addr = off;
              r.data     = wd;
            end
          end else if (sel_reg >= SEL_RTC_FIRST && sel_reg <= SEL_RTC_LAST) begin
            set_rtc_reg(sel_reg - SEL_RTC_FIRST, wd);
          end
        end
      end
      default: ;  // spare mode: no effect
    endcase
    return r;
  endfunction

  task automatic note_fault(input string what);
    fails++;
    if (fails <= 10)
      $display("[%0t] %s: expected tgt=%0d rom=%06h ram=%04h data=%02h, %s",
               $realtime, what, want.target, want.rom_addr, want.ram_addr, want.data,
               $sformatf("got tgt=%0d rom=%06h ram=%04h data=%02h",
                         got.target, got.rom_addr, got.ram_addr, got.data));
  endtask

  // Check the oldest expectation first, then predict the newly accepted item
  always @(posedge clk) begin
    if (rst) begin
      reset_model();
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == bmlr_pkg::CFG_ROM_BANK_COUNT) rom_count = cfg_data[7:0];
        else ram_len = cfg_data;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.target   = m_axis_tuser;
        got.rom_addr = m_axis_tdata[20:0];
        got.ram_addr = m_axis_tdata[35:21];
        got.data     = m_axis_tdata[43:36];
        if (expected_q.size() == 0) begin
          want = '0;
          note_fault("result with nothing outstanding");
        end else begin
          want = expected_q.pop_front();
          n_checked++;
          if (got !== want) note_fault("result mismatch");
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(predict_access(s_axis_tuser, s_axis_tdata[15:0],
                                            s_axis_tdata[23:16]));
    end
    pending   <= expected_q.size();
    err_count <= fails;
    checked   <= n_checked;
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Top of the bank mapper testbench: clock, reset, stimulus and verdict.
// Instantiates bank_mapper_with_latched_rtc and mapper_checker; uses bmlr_pkg.
module testbench;

  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int WIN_RAM_EN   = 16'h0000;
  localparam int WIN_ROM_BANK = 16'h2000;
  localparam int WIN_SELECT   = 16'h4000;
  localparam int WIN_LATCH    = 16'h6000;
  localparam int WIN_END      = 16'h8000;
  localparam int EXT_RAM_LO   = 16'hA000;
  localparam int EXT_RAM_HI   = 16'hBFFF;

  localparam int RAM_SEL_LAST  = 8'h03;
  localparam int SEL_RTC_FIRST = 8'h08;
  localparam int SEL_OTHER     = 8'h0D;
  localparam int RTC_SEC    = 0;
  localparam int RTC_MIN    = 1;
  localparam int RTC_HOUR   = 2;
  localparam int RTC_DAY_LO = 3;
  localparam int RTC_DAY_HI = 4;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 155;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_we = 1'b0;
  logic                             cfg_index = 1'b0;
  logic [15:0]                      cfg_data = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [bmlr_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;   // address[15:0], write_data[23:16]
  logic [1:0]                       s_axis_tuser = '0;   // mode[1:0]
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [bmlr_pkg::OUT_TDATA_W-1:0] m_axis_tdata;        // rom_address[20:0],
                                                         // ram_address[35:21], data[43:36]
  logic [2:0]                       m_axis_tuser;        // target[2:0]

  int err_count, pending, checked;
  int items_sent = 0;
  int geometries = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  int rom_tab [6] = '{1, 128, 3, 128, 77, 1};
  int ram_tab [6] = '{32768, 8192, 5000, 32768, 24576, 0};

  always #5 clk = ~clk;

  bank_mapper_with_latched_rtc u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  mapper_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .err_count     (err_count),
    .pending       (pending),
    .checked       (checked)
  );

  // Stall the result side now and then, except in the quiet stretch
  always @(posedge clk) begin
    if (quiet) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(99, 0) >= 7);
  end

  // Abort when no transaction moves on either side for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one item, with an occasional gap first, and hold until accepted
  task automatic send_item(input int mode, input int addr, input int wd);
    while (!quiet && $urandom_range(99, 0) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {wd[7:0], addr[15:0]};
    s_axis_tuser  <= mode[1:0];
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_geometry(input int banks, input int bytes);
    cfg_we    <= 1'b1;
    cfg_index <= bmlr_pkg::CFG_ROM_BANK_COUNT;
    cfg_data  <= {8'd0, banks[7:0]};
    @(posedge clk);
    cfg_index <= bmlr_pkg::CFG_RAM_BYTES;
    cfg_data  <= bytes[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    geometries++;
  endtask

  task automatic enable_ram();
    send_item(bmlr_pkg::MODE_WRITE, $urandom_range(WIN_ROM_BANK - 1, WIN_RAM_EN),
              ($urandom_range(15, 0) << 4) | 4'hA);
  endtask

  task automatic select(input int sel);
    send_item(bmlr_pkg::MODE_WRITE, $urandom_range(WIN_LATCH - 1, WIN_SELECT), sel);
  endtask

  task automatic put_rtc(input int idx, input int val);
    select(SEL_RTC_FIRST + idx);
    send_item(bmlr_pkg::MODE_WRITE, $urandom_range(EXT_RAM_HI, EXT_RAM_LO), val);
  endtask

  task automatic ticks(input int count);
    for (int i = 0; i < count; i++)
      send_item(bmlr_pkg::MODE_TICK, $urandom_range(65535, 0), $urandom_range(255, 0));
  endtask

  task automatic read_rtc();
    select(SEL_RTC_FIRST + $urandom_range(RTC_DAY_HI, RTC_SEC));
    send_item(bmlr_pkg::MODE_READ, $urandom_range(EXT_RAM_HI, EXT_RAM_LO),
              $urandom_range(255, 0));
  endtask

  // Mostly well-formed access sequences with random content, some noise
  task automatic random_traffic(input int quota);
    int start_n, kind, mode;
    start_n = items_sent;
    while (items_sent - start_n < quota) begin
      kind = $urandom_range(9, 0);
      case (kind)
        0, 1: begin
          if ($urandom_range(1, 0))
            send_item(bmlr_pkg::MODE_WRITE, $urandom_range(WIN_SELECT - 1, WIN_ROM_BANK),
                      $urandom_range(255, 0));
          repeat ($urandom_range(3, 1))
            send_item(bmlr_pkg::MODE_READ, $urandom_range(WIN_END - 1, 0),
                      $urandom_range(255, 0));
        end
        2, 3: begin
          if ($urandom_range(9, 0) == 0)
            send_item(bmlr_pkg::MODE_WRITE, $urandom_range(WIN_ROM_BANK - 1, WIN_RAM_EN),
                      $urandom_range(255, 0));
          else
            enable_ram();
          select(($urandom_range(7, 0) == 0) ? $urandom_range(255, 0)
                                              : $urandom_range(RAM_SEL_LAST, 0));
          repeat ($urandom_range(4, 1))
            send_item($urandom_range(bmlr_pkg::MODE_WRITE, bmlr_pkg::MODE_READ),
                      $urandom_range(EXT_RAM_HI, EXT_RAM_LO), $urandom_range(255, 0));
        end
        4: begin
          enable_ram();
          put_rtc($urandom_range(RTC_DAY_HI, RTC_SEC), $urandom_range(255, 0));
          read_rtc();
        end
        5: begin
          // Park the clock just short of a rollover, then tick across it
          enable_ram();
          put_rtc(RTC_SEC, 59);
          put_rtc(RTC_MIN, $urandom_range(1, 0) ? 59 : $urandom_range(255, 0));
          put_rtc(RTC_HOUR, 23);
          put_rtc(RTC_DAY_LO, $urandom_range(1, 0) ? 8'hFF : $urandom_range(255, 0));
          put_rtc(RTC_DAY_HI, ($urandom_range(7, 0) == 0) ? $urandom_range(255, 0)
                                                          : ($urandom_range(255, 0) & 8'hBF));
          ticks($urandom_range(3, 1));
          read_rtc();
        end
        6: begin
          enable_ram();
          send_item(bmlr_pkg::MODE_WRITE, $urandom_range(WIN_END - 1, WIN_LATCH),
                    $urandom_range(255, 0) & 8'hFE);
          ticks($urandom_range(2, 0));
          send_item(bmlr_pkg::MODE_WRITE, $urandom_range(WIN_END - 1, WIN_LATCH),
                    $urandom_range(255, 0) | 8'h01);
          ticks($urandom_range(2, 1));
          read_rtc();
          if ($urandom_range(1, 0))
            send_item(bmlr_pkg::MODE_WRITE, $urandom_range(WIN_END - 1, WIN_LATCH),
                      $urandom_range(255, 0));
          read_rtc();
        end
        7: ticks($urandom_range(6, 1));
        default: begin
          repeat ($urandom_range(3, 1)) begin
            mode = ($urandom_range(15, 0) == 0) ? MODE_SPARE
                                                : $urandom_range(bmlr_pkg::MODE_TICK, 0);
            send_item(mode, $urandom_range(65535, 0), $urandom_range(255, 0));
          end
        end
      endcase
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: ROM windows, bank zero remap, RTC halt, latch and spare mode
    send_item(bmlr_pkg::MODE_READ, 16'h0000, 8'h00);
    send_item(bmlr_pkg::MODE_READ, 16'h7FFF, 8'hFF);
    send_item(bmlr_pkg::MODE_WRITE, 16'h3FFF, 8'h00);
    send_item(bmlr_pkg::MODE_READ, 16'hFFFF, 8'h00);
    send_item(bmlr_pkg::MODE_WRITE, 16'h0000, 8'h0A);
    send_item(bmlr_pkg::MODE_READ, 16'hA000, 8'h00);
    send_item(bmlr_pkg::MODE_WRITE, 16'h4000, SEL_RTC_FIRST + RTC_DAY_HI);
    send_item(bmlr_pkg::MODE_WRITE, 16'hBFFF, 8'hC1);
    send_item(bmlr_pkg::MODE_TICK, 16'h0000, 8'h00);
    send_item(bmlr_pkg::MODE_WRITE, 16'h6000, 8'h01);
    send_item(bmlr_pkg::MODE_WRITE, 16'h5FFF, SEL_RTC_FIRST + RTC_HOUR);
    send_item(bmlr_pkg::MODE_WRITE, 16'hA000, 8'hFF);
    send_item(bmlr_pkg::MODE_READ, 16'hBFFF, 8'h00);
    send_item(bmlr_pkg::MODE_WRITE, 16'h7FFF, 8'h00);
    send_item(bmlr_pkg::MODE_READ, 16'hA000, 8'h00);
    send_item(bmlr_pkg::MODE_WRITE, 16'h4000, SEL_OTHER);
    send_item(bmlr_pkg::MODE_READ, 16'hA000, 8'h00);
    send_item(MODE_SPARE, 16'hFFFF, 8'hFF);
    send_item(bmlr_pkg::MODE_WRITE, 16'h1FFF, 8'h00);
    send_item(bmlr_pkg::MODE_READ, 16'h4000, 8'h00);

    for (int p = 0; p < 6; p++) begin
      drain();
      if (p == 5) set_geometry($urandom_range(128, 1), $urandom_range(32768, 0));
      else set_geometry(rom_tab[p], ram_tab[p]);
      quiet = (p == 2);
      if (p == 0) begin
        // Single ROM bank and full RAM: top RAM bank, bank register forced to 0
        send_item(bmlr_pkg::MODE_WRITE, 16'h0A5A, 8'h5A);
        send_item(bmlr_pkg::MODE_WRITE, 16'h4000, RAM_SEL_LAST);
        send_item(bmlr_pkg::MODE_WRITE, 16'hBFFF, 8'h5A);
        send_item(bmlr_pkg::MODE_READ, 16'hA000, 8'h00);
        send_item(bmlr_pkg::MODE_WRITE, 16'h2000, 8'h7F);
        send_item(bmlr_pkg::MODE_READ, 16'h4000, 8'h00);
      end
      random_traffic(PHASE_ITEMS);
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Covered %0d reads, writes and ticks over %0d bank/RAM geometries;",
             items_sent, geometries);
    $display("%0d results compared", checked);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* bank_mapper_with_latched_rtc.f */
hdl/bmlr_pkg.sv
hdl/bmlr_ctrl.sv
hdl/bmlr_dp.sv
hdl/bank_mapper_with_latched_rtc.sv
hdl/bmlr_checker.sv
tb/sv/mapper_checker.sv
tb/sv/testbench.sv
